[rtl/wbcd_pkg.sv]
// Package: shared types and constants of the write-back block cache directory.
`timescale 1ns / 1ps
package wbcd_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int TAG_W      = 24;
    localparam int MODE_W     = 2;
    localparam int OUT_SLOT_W = 6;
    localparam int OUT_CNT_W  = 7;
    localparam int TOT_W      = 32;

    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_READ,
        ST_UNLINK,
        ST_APPEND,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic init_step;
        logic start;
        logic scan_step;
        logic pick;
        logic read_links;
        logic unlink;
        logic append;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic init_done;
        logic scan_done;
        logic work;
    } dp_stat_t;

    typedef struct packed {
        logic                  was_hit;
        logic [OUT_SLOT_W-1:0] slot_index;
        logic                  fetch_needed;
        logic                  writeback_valid;
        logic [TAG_W-1:0]      writeback_block;
        logic                  flush_empty;
        logic [OUT_CNT_W-1:0]  dirty_left;
        logic [TOT_W-1:0]      hit_total;
        logic [TOT_W-1:0]      miss_total;
        logic [TOT_W-1:0]      writeback_total;
    } out_item_t;

endpackage

[rtl/wbcd_if.sv]
// Interfaces: request and response channels of the cache directory.
`timescale 1ns / 1ps
interface wbcd_req_if
    import wbcd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [TAG_W-1:0]  block_number;

    modport source (output valid, mode, block_number, input ready);
    modport sink   (input valid, mode, block_number, output ready);
endinterface

interface wbcd_rsp_if
    import wbcd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  was_hit;
    logic [OUT_SLOT_W-1:0] slot_index;
    logic                  fetch_needed;
    logic                  writeback_valid;
    logic [TAG_W-1:0]      writeback_block;
    logic                  flush_empty;
    logic [OUT_CNT_W-1:0]  dirty_left;
    logic [TOT_W-1:0]      hit_total;
    logic [TOT_W-1:0]      miss_total;
    logic [TOT_W-1:0]      writeback_total;

    modport source (output valid, was_hit, slot_index, fetch_needed, writeback_valid,
                    writeback_block, flush_empty, dirty_left, hit_total, miss_total,
                    writeback_total, input ready);
    modport sink   (input valid, was_hit, slot_index, fetch_needed, writeback_valid,
                    writeback_block, flush_empty, dirty_left, hit_total, miss_total,
                    writeback_total, output ready);
endinterface

[rtl/wbcd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wbcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/wbcd_dp.sv]
// Datapath: slot bits, recency lists, link and tag memories, counters, result register.
`timescale 1ns / 1ps
module wbcd_dp
    import wbcd_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] in_mode,
    input  logic [TAG_W-1:0]  in_block,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output out_item_t         item
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [SLOTS-1:0]  valid_reg, valid_next, dirty_reg, dirty_next;
    logic [IW-1:0]     c_old_reg, c_old_next, c_new_reg, c_new_next;
    logic [IW-1:0]     d_old_reg, d_old_next, d_new_reg, d_new_next;
    logic [CW-1:0]     c_cnt_reg, c_cnt_next, d_cnt_reg, d_cnt_next;
    logic [TOT_W-1:0]  hits_reg, hits_next, miss_reg, miss_next, wbs_reg, wbs_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     slot_reg, slot_next;
    logic              hit_reg, hit_next, fetch_reg, fetch_next, wbv_reg, wbv_next;
    logic              fempty_reg, fempty_next;
    logic              from_d_reg, from_d_next, to_d_reg, to_d_next;
    logic              unl_reg, unl_next, isfill_reg, isfill_next, isflush_reg, isflush_next;
    logic [TAG_W-1:0]  wbb_reg, wbb_next;
    out_item_t         out_reg, out_next;

    logic              nl_we, ol_we, tg_we, tg_re, lk_re;
    logic [IW-1:0]     nl_wa, ol_wa, tg_ra, nl_wd, ol_wd, nl_rd, ol_rd;
    logic [TAG_W-1:0]  tg_rd;
    logic              rw, match;
    logic [IW-1:0]     l_old, l_new, t_new;
    logic [CW-1:0]     l_cnt, t_cnt;
    logic [IW-1:0]     init_a;

    wbcd_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_newer (
        .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd),
        .re(lk_re), .raddr(slot_reg), .rdata(nl_rd)
    );
    wbcd_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_older (
        .clk(clk), .we(ol_we), .waddr(ol_wa), .wdata(ol_wd),
        .re(lk_re), .raddr(slot_reg), .rdata(ol_rd)
    );
    wbcd_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag (
        .clk(clk), .we(tg_we), .waddr(slot_reg), .wdata(tag_reg),
        .re(tg_re), .raddr(tg_ra), .rdata(tg_rd)
    );

    assign rw     = (mode_reg == MODE_READ) || (mode_reg == MODE_WRITE);
    assign match  = cmp_vld_reg && valid_reg[cmp_idx_reg] && (tg_rd == tag_reg);
    assign init_a = scan_reg[IW-1:0];
    assign stat.init_done = (init_a == LAST);
    assign stat.scan_done = !rw || match || (cmp_vld_reg && (cmp_idx_reg == LAST));
    assign stat.work      = rw || ((mode_reg == MODE_FLUSH) && (d_cnt_reg != '0));
    assign item = out_reg;

    assign tg_re = cmd.scan_step || cmd.read_links;
    assign tg_ra = cmd.read_links ? slot_reg : scan_reg[IW-1:0];
    assign lk_re = cmd.read_links;
    assign tg_we = cmd.unlink && isfill_reg;

    always_comb
    begin
        mode_next = mode_reg;       tag_next = tag_reg;
        valid_next = valid_reg;     dirty_next = dirty_reg;
        c_old_next = c_old_reg;     c_new_next = c_new_reg;
        d_old_next = d_old_reg;     d_new_next = d_new_reg;
        c_cnt_next = c_cnt_reg;     d_cnt_next = d_cnt_reg;
        hits_next = hits_reg;       miss_next = miss_reg;       wbs_next = wbs_reg;
        scan_next = scan_reg;       cmp_idx_next = cmp_idx_reg; cmp_vld_next = cmp_vld_reg;
        found_next = found_reg;     slot_next = slot_reg;
        hit_next = hit_reg;         fetch_next = fetch_reg;     wbv_next = wbv_reg;
        fempty_next = fempty_reg;   from_d_next = from_d_reg;   to_d_next = to_d_reg;
        unl_next = unl_reg;         isfill_next = isfill_reg;   isflush_next = isflush_reg;
        wbb_next = wbb_reg;         out_next = out_reg;
        nl_we = 1'b0; nl_wa = '0; nl_wd = '0;
        ol_we = 1'b0; ol_wa = '0; ol_wd = '0;
        l_old = from_d_reg ? d_old_reg : c_old_reg;
        l_new = from_d_reg ? d_new_reg : c_new_reg;
        l_cnt = from_d_reg ? d_cnt_reg : c_cnt_reg;
        t_new = to_d_reg ? d_new_reg : c_new_reg;
        t_cnt = to_d_reg ? d_cnt_reg : c_cnt_reg;

        if (cmd.init_step)
        begin
            // seed the link rings: slot i points to i+1 and i-1
            nl_we = 1'b1; nl_wa = init_a;
            nl_wd = (init_a == LAST) ? '0 : init_a + 1'b1;
            ol_we = 1'b1; ol_wa = init_a;
            ol_wd = (init_a == '0) ? LAST : init_a - 1'b1;
            scan_next = scan_reg + 1'b1;
        end

        if (cmd.start)
        begin
            mode_next = in_mode;  tag_next = in_block;
            scan_next = '0;       cmp_vld_next = 1'b0;  found_next = 1'b0;
            slot_next = '0;       hit_next = 1'b0;      fetch_next = 1'b0;
            wbv_next = 1'b0;      fempty_next = 1'b0;   wbb_next = '0;
            unl_next = 1'b0;      isfill_next = 1'b0;   isflush_next = 1'b0;
        end

        if (cmd.scan_step)
        begin
            if (match)
            begin
                found_next = 1'b1;
                slot_next  = cmp_idx_reg;
            end
            cmp_vld_next = (scan_reg < CW'(SLOTS));
            cmp_idx_next = scan_reg[IW-1:0];
            if (scan_reg < CW'(SLOTS))
            begin
                scan_next = scan_reg + 1'b1;
            end
        end

        if (cmd.pick)
        begin
            if (rw)
            begin
                if (found_reg)
                begin
                    hit_next    = 1'b1;
                    hits_next   = hits_reg + 1'b1;
                    from_d_next = dirty_reg[slot_reg];
                    to_d_next   = dirty_reg[slot_reg] || (mode_reg == MODE_WRITE);
                    unl_next    = 1'b1;
                end
                else
                begin
                    fetch_next  = 1'b1;
                    miss_next   = miss_reg + 1'b1;
                    isfill_next = 1'b1;
                    to_d_next   = (mode_reg == MODE_WRITE);
                    if (c_cnt_reg != '0)
                    begin
                        slot_next = c_old_reg; from_d_next = 1'b0; unl_next = 1'b1;
                    end
                    else if (d_cnt_reg != '0)
                    begin
                        slot_next = d_old_reg; from_d_next = 1'b1; unl_next = 1'b1;
                        wbv_next  = 1'b1;      wbs_next = wbs_reg + 1'b1;
                    end
                    else
                    begin
                        slot_next = '0;
                    end
                end
            end
            else if (mode_reg == MODE_FLUSH)
            begin
                if (d_cnt_reg == '0)
                begin
                    fempty_next = 1'b1;
                end
                else
                begin
                    slot_next    = d_old_reg; from_d_next = 1'b1; to_d_next = 1'b0;
                    unl_next     = 1'b1;      wbv_next = 1'b1;
                    wbs_next     = wbs_reg + 1'b1;
                    isflush_next = 1'b1;
                end
            end
        end

        if (cmd.unlink)
        begin
            wbb_next = wbv_reg ? tg_rd : '0;
            dirty_next[slot_reg] = to_d_reg;
            if (isflush_reg)
            begin
                valid_next[slot_reg] = 1'b0;
            end
            else if (isfill_reg)
            begin
                valid_next[slot_reg] = 1'b1;
            end
            if (unl_reg && (l_cnt != '0))
            begin
                if (l_cnt == CW'(1))
                begin
                    // last member leaves: ends stay, count drops
                end
                else if (slot_reg == l_old)
                begin
                    l_old = nl_rd;
                end
                else if (slot_reg == l_new)
                begin
                    l_new = ol_rd;
                end
                else
                begin
                    nl_we = 1'b1; nl_wa = ol_rd; nl_wd = nl_rd;
                    ol_we = 1'b1; ol_wa = nl_rd; ol_wd = ol_rd;
                end
                l_cnt = l_cnt - 1'b1;
                if (from_d_reg)
                begin
                    d_old_next = l_old; d_new_next = l_new; d_cnt_next = l_cnt;
                end
                else
                begin
                    c_old_next = l_old; c_new_next = l_new; c_cnt_next = l_cnt;
                end
            end
        end

        if (cmd.append)
        begin
            if (t_cnt != '0)
            begin
                nl_we = 1'b1; nl_wa = t_new;    nl_wd = slot_reg;
                ol_we = 1'b1; ol_wa = slot_reg; ol_wd = t_new;
            end
            if (to_d_reg)
            begin
                if (t_cnt == '0)
                begin
                    d_old_next = slot_reg;
                end
                d_new_next = slot_reg;
                d_cnt_next = d_cnt_reg + 1'b1;
            end
            else
            begin
                if (t_cnt == '0)
                begin
                    c_old_next = slot_reg;
                end
                c_new_next = slot_reg;
                c_cnt_next = c_cnt_reg + 1'b1;
            end
        end

        if (cmd.load_out)
        begin
            out_next.was_hit         = hit_reg;
            out_next.slot_index      = OUT_SLOT_W'(slot_reg);
            out_next.fetch_needed    = fetch_reg;
            out_next.writeback_valid = wbv_reg;
            out_next.writeback_block = wbb_reg;
            out_next.flush_empty     = fempty_reg;
            out_next.dirty_left      = OUT_CNT_W'(d_cnt_reg);
            out_next.hit_total       = hits_reg;
            out_next.miss_total      = miss_reg;
            out_next.writeback_total = wbs_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;          dirty_reg <= '0;
            c_old_reg <= '0;          c_new_reg <= LAST;
            d_old_reg <= '0;          d_new_reg <= '0;
            c_cnt_reg <= CW'(SLOTS);  d_cnt_reg <= '0;
            hits_reg  <= '0;          miss_reg  <= '0;     wbs_reg <= '0;
            scan_reg  <= '0;          cmp_vld_reg <= 1'b0; found_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;  dirty_reg <= dirty_next;
            c_old_reg <= c_old_next;  c_new_reg <= c_new_next;
            d_old_reg <= d_old_next;  d_new_reg <= d_new_next;
            c_cnt_reg <= c_cnt_next;  d_cnt_reg <= d_cnt_next;
            hits_reg  <= hits_next;   miss_reg  <= miss_next;  wbs_reg <= wbs_next;
            scan_reg  <= scan_next;   cmp_vld_reg <= cmp_vld_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;       tag_reg <= tag_next;
        cmp_idx_reg <= cmp_idx_next; slot_reg <= slot_next;
        hit_reg <= hit_next;         fetch_reg <= fetch_next;   wbv_reg <= wbv_next;
        fempty_reg <= fempty_next;   from_d_reg <= from_d_next; to_d_reg <= to_d_next;
        unl_reg <= unl_next;         isfill_reg <= isfill_next; isflush_reg <= isflush_next;
        wbb_reg <= wbb_next;         out_reg <= out_next;
    end
endmodule

[rtl/wbcd_ctrl.sv]
// Controller: sequences init sweep, tag scan, list updates and the handshakes.
`timescale 1ns / 1ps
module wbcd_ctrl
    import wbcd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    ctrl_state_t state_reg, state_next;
    logic        ovld_reg, ovld_next;

    assign out_valid = ovld_reg;

    always_comb
    begin
        state_next = state_reg;
        ovld_next  = ovld_reg && !out_ready;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = stat.work ? ST_READ : ST_FINISH;
            end
            ST_READ:
            begin
                cmd.read_links = 1'b1;
                state_next     = ST_UNLINK;
            end
            ST_UNLINK:
            begin
                cmd.unlink = 1'b1;
                state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the result register is free
                if (!ovld_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end
endmodule

[rtl/writeback_block_cache_directory.sv]
// Top level: write-back block cache directory, fully associative, clean-first LRU.
//
// Channels: req carries one item per request (mode: read, write or flush one dirty
// block; block_number: disk block). rsp carries one result item per request: hit,
// slot, fetch and write-back advice, the dirty count and the wrapping totals.
// Both use valid/ready; an item moves when both are high at a clock edge.
// A read or write scans the tag memory one slot per cycle and stops at the first
// match; a flush or an unused mode does not search the tags. The single-port tag
// scan sets the pace of a lookup.
// One request is worked on at a time; the next is taken in the cycle after the
// current one has reached the result register.
// Reset: all slots become free and clean, counters clear; then the link memories
// are seeded in a sweep over all slots, during which req.ready stays low.
// Stall: a result waits in the result register while rsp.ready is low; the block
// still takes and works on the next item, then holds it until the register frees.
`timescale 1ns / 1ps
module writeback_block_cache_directory
    import wbcd_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    wbcd_req_if.sink    req,
    wbcd_rsp_if.source  rsp
);
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    out_item_t item;

    // sequence the work
    wbcd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat(stat), .cmd(cmd)
    );

    // hold the directory state and results
    wbcd_dp #(.SLOTS(SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_mode(req.mode), .in_block(req.block_number),
        .cmd(cmd), .stat(stat), .item(item)
    );

    assign rsp.was_hit         = item.was_hit;
    assign rsp.slot_index      = item.slot_index;
    assign rsp.fetch_needed    = item.fetch_needed;
    assign rsp.writeback_valid = item.writeback_valid;
    assign rsp.writeback_block = item.writeback_block;
    assign rsp.flush_empty     = item.flush_empty;
    assign rsp.dirty_left      = item.dirty_left;
    assign rsp.hit_total       = item.hit_total;
    assign rsp.miss_total      = item.miss_total;
    assign rsp.writeback_total = item.writeback_total;
endmodule

[tb/sv/writeback_block_cache_directory_tb.sv]
// Testbench: directed table and random traffic checked against a directory predictor.
`timescale 1ns / 1ps
module writeback_block_cache_directory_tb;
    import wbcd_pkg::*;

    localparam int NSLOT      = SLOTS_DEF;
    localparam int RAND_ITEMS = 967;
    localparam int WD_LIMIT   = 4000;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    logic clk;
    logic rst_n;

    wbcd_req_if req_ch ();
    wbcd_rsp_if rsp_ch ();

    writeback_block_cache_directory u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Predictor state: slot tags, marks, and the two recency lists.
    logic [TAG_W-1:0] dir_tag [NSLOT];
    bit               dir_valid [NSLOT];
    bit               dir_dirty [NSLOT];
    int unsigned      link_newer [NSLOT];
    int unsigned      link_older [NSLOT];
    int unsigned      cl_old, cl_new, cl_cnt;
    int unsigned      dt_old, dt_new, dt_cnt;
    logic [TOT_W-1:0] n_hits, n_misses, n_wbs;

    out_item_t   pending_results [$];
    // Directed rows carry a typed-in expectation where it is obvious.
    out_item_t   fixed_result [$];
    bit          fixed_given [$];

    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned accept_count;
    int unsigned idle_cycles;
    int unsigned hit_seen, wb_seen, empty_seen;
    bit          timed_out;
    bit          stim_done;

    // Recently used blocks, so random traffic hits often.
    logic [TAG_W-1:0] recent_blocks [$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void dir_reset();
        for (int i = 0; i < NSLOT; i++)
        begin
            dir_tag[i]    = '0;
            dir_valid[i]  = 1'b0;
            dir_dirty[i]  = 1'b0;
            link_newer[i] = (i + 1) % NSLOT;
            link_older[i] = (i + NSLOT - 1) % NSLOT;
        end
        cl_old = 0;
        cl_new = NSLOT - 1;
        cl_cnt = NSLOT;
        dt_old = 0;
        dt_new = 0;
        dt_cnt = 0;
        n_hits = '0;
        n_misses = '0;
        n_wbs = '0;
    endfunction

    // Unlink a slot from the list that holds it; head and tail just move.
    function automatic void list_drop(int unsigned s, bit from_dirty);
        int unsigned o;
        int unsigned n;
        if (from_dirty)
        begin
            if (dt_cnt == 0) return;
            if (dt_cnt == 1) begin dt_cnt = 0; return; end
            if (s == dt_old) dt_old = link_newer[s];
            else if (s == dt_new) dt_new = link_older[s];
            else
            begin
                o = link_older[s];
                n = link_newer[s];
                link_newer[o] = n;
                link_older[n] = o;
            end
            dt_cnt--;
        end
        else
        begin
            if (cl_cnt == 0) return;
            if (cl_cnt == 1) begin cl_cnt = 0; return; end
            if (s == cl_old) cl_old = link_newer[s];
            else if (s == cl_new) cl_new = link_older[s];
            else
            begin
                o = link_older[s];
                n = link_newer[s];
                link_newer[o] = n;
                link_older[n] = o;
            end
            cl_cnt--;
        end
    endfunction

    function automatic void list_push(int unsigned s, bit to_dirty);
        if (to_dirty)
        begin
            if (dt_cnt == 0) begin dt_old = s; dt_new = s; end
            else
            begin
                link_newer[dt_new] = s;
                link_older[s] = dt_new;
                dt_new = s;
            end
            dt_cnt++;
        end
        else
        begin
            if (cl_cnt == 0) begin cl_old = s; cl_new = s; end
            else
            begin
                link_newer[cl_new] = s;
                link_older[s] = cl_new;
                cl_new = s;
            end
            cl_cnt++;
        end
    endfunction

    // Work out the result of one request and advance the directory.
    function automatic out_item_t dir_lookup(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] blk);
        out_item_t   r;
        bit          found;
        int unsigned s;
        r = '0;
        found = 1'b0;
        s = 0;
        if (mode == MODE_READ || mode == MODE_WRITE)
        begin
            for (int i = 0; i < NSLOT; i++)
                if (!found && dir_valid[i] && dir_tag[i] == blk)
                begin
                    found = 1'b1;
                    s = i;
                end
            if (found)
            begin
                r.was_hit = 1'b1;
                n_hits++;
                list_drop(s, dir_dirty[s]);
                if (mode == MODE_WRITE) dir_dirty[s] = 1'b1;
            end
            else
            begin
                r.fetch_needed = 1'b1;
                n_misses++;
                if (cl_cnt > 0)
                begin
                    s = cl_old;
                    list_drop(s, 1'b0);
                end
                else if (dt_cnt > 0)
                begin
                    s = dt_old;
                    r.writeback_valid = 1'b1;
                    r.writeback_block = dir_tag[s];
                    n_wbs++;
                    list_drop(s, 1'b1);
                end
                dir_tag[s]   = blk;
                dir_valid[s] = 1'b1;
                dir_dirty[s] = (mode == MODE_WRITE);
            end
            list_push(s, dir_dirty[s]);
        end
        else if (mode == MODE_FLUSH)
        begin
            if (dt_cnt == 0) r.flush_empty = 1'b1;
            else
            begin
                s = dt_old;
                r.writeback_valid = 1'b1;
                r.writeback_block = dir_tag[s];
                n_wbs++;
                list_drop(s, 1'b1);
                dir_valid[s] = 1'b0;
                dir_dirty[s] = 1'b0;
                list_push(s, 1'b0);
            end
        end
        r.slot_index      = s[OUT_SLOT_W-1:0];
        r.dirty_left      = dt_cnt[OUT_CNT_W-1:0];
        r.hit_total       = n_hits;
        r.miss_total      = n_misses;
        r.writeback_total = n_wbs;
        return r;
    endfunction

    // Gap length: mostly zero or short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [TAG_W-1:0] pick_block();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55 && recent_blocks.size() > 0)
            return recent_blocks[$urandom_range(recent_blocks.size() - 1)];
        if (p < 65)
            return $urandom_range(3) == 0 ? {TAG_W{1'b1}} : TAG_W'($urandom_range(3));
        return TAG_W'($urandom);
    endfunction

    // Drop valid for a gap, then hold valid and payload until the item is taken.
    task automatic send_item(logic [MODE_W-1:0] mode, logic [TAG_W-1:0] blk);
        int unsigned g;
        g = gap_len();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= mode;
        req_ch.block_number <= blk;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // Predict on acceptance so the queue follows block order.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            out_item_t e;
            e = dir_lookup(req_ch.mode, req_ch.block_number);
            if (fixed_given.size() > 0 && fixed_given.pop_front())
                e = fixed_result.pop_front();
            pending_results.push_back(e);
            accept_count++;
        end
    end

    // Check each result item against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            out_item_t got;
            out_item_t exp_r;
            got.was_hit         = rsp_ch.was_hit;
            got.slot_index      = rsp_ch.slot_index;
            got.fetch_needed    = rsp_ch.fetch_needed;
            got.writeback_valid = rsp_ch.writeback_valid;
            got.writeback_block = rsp_ch.writeback_block;
            got.flush_empty     = rsp_ch.flush_empty;
            got.dirty_left      = rsp_ch.dirty_left;
            got.hit_total       = rsp_ch.hit_total;
            got.miss_total      = rsp_ch.miss_total;
            got.writeback_total = rsp_ch.writeback_total;
            result_count++;
            if (got.was_hit) hit_seen++;
            if (got.writeback_valid) wb_seen++;
            if (got.flush_empty) empty_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with nothing expected", result_count);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: exp hit=%0b slot=%0d fetch=%0b wb=%0b/%h empty=%0b dirty=%0d tot=%0d/%0d/%0d, got hit=%0b slot=%0d fetch=%0b wb=%0b/%h empty=%0b dirty=%0d tot=%0d/%0d/%0d",
                            result_count, exp_r.was_hit, exp_r.slot_index,
                            exp_r.fetch_needed, exp_r.writeback_valid,
                            exp_r.writeback_block, exp_r.flush_empty, exp_r.dirty_left,
                            exp_r.hit_total, exp_r.miss_total, exp_r.writeback_total,
                            got.was_hit, got.slot_index, got.fetch_needed,
                            got.writeback_valid, got.writeback_block, got.flush_empty,
                            got.dirty_left, got.hit_total, got.miss_total,
                            got.writeback_total);
                end
            end
        end
    end

    // Throttle the result side: runs of stall, runs of open flow.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int unsigned g;
            g = gap_len();
            rsp_ch.ready <= (g == 0);
            repeat (g == 0 ? $urandom_range(12, 1) : g) @(posedge clk);
        end
    end

    // Watchdog: count cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WD_LIMIT && !stim_done)
        begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [TAG_W-1:0]  blk;
        bit                fixed;
        out_item_t         res;
    } stim_row_t;

    stim_row_t stim_table [$];

    function automatic out_item_t mk(bit h, int s, bit f, bit wv, logic [TAG_W-1:0] wb,
                                     bit fe, int dl, int ht, int mt, int wt);
        out_item_t r;
        r.was_hit = h;
        r.slot_index = OUT_SLOT_W'(s);
        r.fetch_needed = f;
        r.writeback_valid = wv;
        r.writeback_block = wb;
        r.flush_empty = fe;
        r.dirty_left = OUT_CNT_W'(dl);
        r.hit_total = TOT_W'(ht);
        r.miss_total = TOT_W'(mt);
        r.writeback_total = TOT_W'(wt);
        return r;
    endfunction

    function automatic void add_row(logic [MODE_W-1:0] m, logic [TAG_W-1:0] b,
                                    bit fx, out_item_t r);
        stim_row_t t;
        t.mode = m;
        t.blk = b;
        t.fixed = fx;
        t.res = r;
        stim_table.push_back(t);
    endfunction

    initial
    begin
        int unsigned cnt;
        int unsigned drain;
        logic [MODE_W-1:0] m;
        logic [TAG_W-1:0]  b;
        int unsigned p;
        mismatch_count = 0;
        result_count = 0;
        accept_count = 0;
        hit_seen = 0;
        wb_seen = 0;
        empty_seen = 0;
        timed_out = 1'b0;
        stim_done = 1'b0;
        idle_cycles = 0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_READ;
        req_ch.block_number = '0;
        rst_n = 1'b0;
        dir_reset();

        // Directed table: after reset, extremes, every mode, empty flush, unused mode.
        add_row(MODE_FLUSH, 24'h000000, 1, mk(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        add_row(MODE_NONE,  24'hFFFFFF, 1, mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(MODE_READ,  24'h000000, 1, mk(0, 0, 1, 0, 0, 0, 0, 0, 1, 0));
        add_row(MODE_READ,  24'h000000, 1, mk(1, 0, 0, 0, 0, 0, 0, 1, 1, 0));
        add_row(MODE_WRITE, 24'hFFFFFF, 1, mk(0, 1, 1, 0, 0, 0, 1, 1, 2, 0));
        add_row(MODE_WRITE, 24'h000000, 1, mk(1, 0, 0, 0, 0, 0, 2, 2, 2, 0));
        add_row(MODE_READ,  24'hFFFFFF, 1, mk(1, 1, 0, 0, 0, 0, 2, 3, 2, 0));
        add_row(MODE_FLUSH, 24'h123456, 1, mk(0, 0, 0, 1, 24'h000000, 0, 1, 3, 2, 1));
        add_row(MODE_NONE,  24'h000001, 0, '0);
        add_row(MODE_READ,  24'hAAAAAA, 0, '0);
        add_row(MODE_WRITE, 24'h555555, 0, '0);
        add_row(MODE_READ,  24'hFFFFFF, 0, '0);
        add_row(MODE_FLUSH, 24'h000000, 0, '0);
        add_row(MODE_FLUSH, 24'h000000, 0, '0);
        add_row(MODE_FLUSH, 24'h000000, 0, '0);
        // Fill every slot dirty, then three more writes evict with write-back.
        for (int i = 0; i < NSLOT + 3; i++)
            add_row(MODE_WRITE, TAG_W'(24'h800000 + i), 0, '0);
        add_row(MODE_READ, 24'h800001, 0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            fixed_given.push_back(stim_table[i].fixed);
            if (stim_table[i].fixed) fixed_result.push_back(stim_table[i].res);
            send_item(stim_table[i].mode, stim_table[i].blk);
        end

        // Random part: mostly reads and writes on a small working set.
        cnt = 0;
        while (cnt < RAND_ITEMS)
        begin
            p = $urandom_range(99);
            if (p < 45) m = MODE_READ;
            else if (p < 85) m = MODE_WRITE;
            else if (p < 97) m = MODE_FLUSH;
            else m = MODE_NONE;
            b = pick_block();
            if (m != MODE_FLUSH)
            begin
                recent_blocks.push_back(b);
                if (recent_blocks.size() > 90) void'(recent_blocks.pop_front());
            end
            send_item(m, b);
            cnt++;
        end
        req_ch.valid <= 1'b0;

        // Drain: wait for every expected item, then idle on before the summary.
        drain = 0;
        while (pending_results.size() > 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (3 * NSLOT) @(posedge clk);
        stim_done = 1'b1;

        $display("covered %0d requests, %0d results: %0d hits, %0d write-backs, %0d empty flushes",
                 accept_count, result_count, hit_seen, wb_seen, empty_seen);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_results.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/wbcd_pkg.sv
rtl/wbcd_if.sv
rtl/wbcd_ram.sv
rtl/wbcd_dp.sv
rtl/wbcd_ctrl.sv
rtl/writeback_block_cache_directory.sv
tb/sv/writeback_block_cache_directory_tb.sv
